/* design/tdssm_pkg.sv */
// Shared types, constants and glyph functions for the three-digit
// seven-segment display driver. No dependencies.
`timescale 1ns / 1ps

package tdssm_pkg;

    localparam int DIGIT_COUNT = 3;

    localparam logic [7:0] DOT_ON_MASK = 8'b0111_1111;
    localparam logic [7:0] DOT_OFF_BIT = 8'b1000_0000;
    localparam logic [5:0] GLYPH_MINUS = 6'd36;
    localparam logic [5:0] GLYPH_SPACE = 6'd37;
    localparam logic [7:0] RESET_PATTERN = 8'd130;

    localparam logic signed [15:0] NUMBER_MIN = -16'sd99;
    localparam logic signed [15:0] NUMBER_MAX = 16'sd999;

    typedef enum logic [1:0] {
        OP_TICK         = 2'd0,
        OP_WRITE_NUMBER = 2'd1,
        OP_WRITE_CHAR   = 2'd2,
        OP_UNUSED       = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] number;
        logic [1:0]         digit_index;
        logic [7:0]         char_code;
        logic               dot_on;
    } item_t;

    typedef struct packed {
        logic [7:0] segment_lines;
        logic [2:0] digit_enables;
    } result_t;

    typedef logic [DIGIT_COUNT-1:0][7:0] pattern_array_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] index;
    } glyph_sel_t;

    // Lit segments, active high, a..g in bits 0..6.
    function automatic logic [6:0] glyph_lit(input logic [5:0] index);
        logic [6:0] lit;
        case (index)
            6'd0:  lit = 7'h3F;
            6'd1:  lit = 7'h06;
            6'd2:  lit = 7'h5B;
            6'd3:  lit = 7'h4F;
            6'd4:  lit = 7'h66;
            6'd5:  lit = 7'h6D;
            6'd6:  lit = 7'h7D;
            6'd7:  lit = 7'h07;
            6'd8:  lit = 7'h7F;
            6'd9:  lit = 7'h6F;
            6'd10: lit = 7'h77;
            6'd11: lit = 7'h7C;
            6'd12: lit = 7'h39;
            6'd13: lit = 7'h5E;
            6'd14: lit = 7'h79;
            6'd15: lit = 7'h71;
            6'd16: lit = 7'h3D;
            6'd17: lit = 7'h74;
            6'd18: lit = 7'h04;
            6'd19: lit = 7'h1E;
            6'd20: lit = 7'h75;
            6'd21: lit = 7'h38;
            6'd22: lit = 7'h15;
            6'd23: lit = 7'h54;
            6'd24: lit = 7'h5C;
            6'd25: lit = 7'h73;
            6'd26: lit = 7'h67;
            6'd27: lit = 7'h50;
            6'd28: lit = 7'h2D;
            6'd29: lit = 7'h78;
            6'd30: lit = 7'h1C;
            6'd31: lit = 7'h1C;
            6'd32: lit = 7'h3E;
            6'd33: lit = 7'h76;
            6'd34: lit = 7'h6E;
            6'd35: lit = 7'h1B;
            6'd36: lit = 7'h40;
            default: lit = 7'h00;
        endcase
        return lit;
    endfunction

    // Stored patterns are active low; the dot sits in bit 7.
    function automatic logic [7:0] glyph_pattern(input logic [5:0] index, input logic dot);
        logic [7:0] p;
        p = {1'b1, ~glyph_lit(index)};
        if (dot)
            p = p & DOT_ON_MASK;
        else
            p = p | DOT_OFF_BIT;
        return p;
    endfunction

    function automatic glyph_sel_t char_to_glyph(input logic [7:0] code);
        glyph_sel_t sel;
        sel.ok    = 1'b1;
        sel.index = GLYPH_SPACE;
        if (code inside {[8'h30:8'h39]})
            sel.index = 6'(code - 8'h30);
        else if (code inside {[8'h41:8'h5A]})
            sel.index = 6'(code - 8'h37);
        else if (code inside {[8'h61:8'h7A]})
            sel.index = 6'(code - 8'h57);
        else if (code == 8'h2D)
            sel.index = GLYPH_MINUS;
        else if (code == 8'h20)
            sel.index = GLYPH_SPACE;
        else
            sel.ok = 1'b0;
        return sel;
    endfunction

endpackage

/* design/three_digit_seven_segment_mux_unit.sv */
// Top level of the three-digit seven-segment display driver.
// Depends on tdssm_pkg and tdssm_writer.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one command word per handshake (valid high,
// stall low): a scan tick, a number write or a character write. Writes
// update the stored digit patterns at the accepting edge and give no word
// on the rsp channel. A scan tick advances the scan position and yields one
// rsp word holding that digit's active-low segment lines and its active-low
// digit enable.
// Latency: an rsp word is valid in the cycle after its tick is accepted, when the output is free.
// Throughput: one command word per cycle while req_stall is low, set by the
// pattern registers updating at each accepting edge and a two-entry output buffer.
// Reset: the digits show "666" with the dots off, the scan position is 0
// and the output buffer is empty.
// Stall: a stalled rsp word holds steady; one further tick is parked in a
// skid register, and req_stall rises only while that register is full.
// Writes behind a held word are applied at once and never disturb it.

module three_digit_seven_segment_mux_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tdssm_pkg::item_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output tdssm_pkg::result_t rsp
);
    import tdssm_pkg::*;

    pattern_array_t patterns_reg;
    pattern_array_t patterns_next;
    pattern_array_t patterns_written;
    logic [1:0]     scan_reg;
    logic [1:0]     scan_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    result_t        out_reg;
    result_t        out_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    result_t        skid_reg;
    result_t        skid_next;

    logic           accept;
    logic           tick;
    logic [1:0]     tick_pos;
    result_t        tick_result;
    logic           out_free;

    tdssm_writer u_writer (
        .item          (req),
        .patterns      (patterns_reg),
        .patterns_next (patterns_written)
    );

    always_comb
    begin
        accept   = req_valid && !req_stall;
        tick     = accept && (op_t'(req.operation) == OP_TICK);
        tick_pos = (scan_reg == 2'(DIGIT_COUNT - 1)) ? 2'd0 : 2'(scan_reg + 2'd1);

        tick_result.segment_lines = patterns_reg[tick_pos];
        tick_result.digit_enables = ~(3'b001 << tick_pos);

        patterns_next = accept ? patterns_written : patterns_reg;
        scan_next     = tick ? tick_pos : scan_reg;

        out_free        = !out_valid_reg || !rsp_stall;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = tick;
                out_next       = tick_result;
            end
        end
        else if (tick)
        begin
            skid_valid_next = 1'b1;
            skid_next       = tick_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patterns_reg   <= {DIGIT_COUNT{RESET_PATTERN}};
            scan_reg       <= 2'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            patterns_reg   <= patterns_next;
            scan_reg       <= scan_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign req_stall = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg != 2'd3)
        else $error("scan position left the digit range");

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register is empty");

    a_one_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($countones(~out_reg.digit_enables) == 1))
        else $error("output word enables other than exactly one digit");

    a_enable_matches_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && out_free && !skid_valid_reg) |=> (out_reg.digit_enables[scan_reg] == 1'b0))
        else $error("digit enable does not match the scan position");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !rsp_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid register did not move into the output register");
`endif

endmodule

/* design/tdssm_writer.sv */
// Computes the digit patterns after a number or character write.
// Depends on tdssm_pkg.
`timescale 1ns / 1ps

module tdssm_writer (
    input  tdssm_pkg::item_t          item,
    input  tdssm_pkg::pattern_array_t patterns,
    output tdssm_pkg::pattern_array_t patterns_next
);
    import tdssm_pkg::*;

    logic               in_range;
    logic               negative;
    logic [15:0]        negated;
    logic [9:0]         value;
    logic [15:0]        hundreds_prod;
    logic [3:0]         hundreds;
    logic [9:0]         below_hundred;
    logic [6:0]         two_digits;
    logic [14:0]        tens_prod;
    logic [3:0]         tens;
    logic [6:0]         ones_wide;
    logic [3:0]         ones;
    glyph_sel_t         char_sel;

    always_comb
    begin
        in_range = (item.number >= NUMBER_MIN) && (item.number <= NUMBER_MAX);
        negative = item.number[15];
        negated  = 16'(-item.number);
        value    = item.number[9:0];

        // Multiply by reciprocals: exact for 0..999 and 0..99 respectively.
        hundreds_prod = 16'(value) * 16'd41;
        hundreds      = hundreds_prod[15:12];
        below_hundred = 10'(value - (10'(hundreds) * 10'd100));
        two_digits    = negative ? negated[6:0] : below_hundred[6:0];
        tens_prod     = 15'(two_digits) * 15'd205;
        tens          = tens_prod[14:11];
        ones_wide     = 7'(two_digits - (7'(tens) * 7'd10));
        ones          = ones_wide[3:0];

        char_sel = char_to_glyph(item.char_code);

        patterns_next = patterns;
        case (op_t'(item.operation))
            OP_WRITE_NUMBER:
            begin
                if (in_range)
                begin
                    patterns_next[2] = negative ? glyph_pattern(GLYPH_MINUS, 1'b0)
                                                : glyph_pattern({2'b00, hundreds}, 1'b0);
                    patterns_next[1] = glyph_pattern({2'b00, tens}, 1'b0);
                    patterns_next[0] = glyph_pattern({2'b00, ones}, 1'b0);
                end
            end
            OP_WRITE_CHAR:
            begin
                if (char_sel.ok && item.digit_index != 2'd3)
                    patterns_next[item.digit_index] = glyph_pattern(char_sel.index, item.dot_on);
            end
            default:
            begin
                patterns_next = patterns;
            end
        endcase
    end

endmodule

/* bench/tdssm_display_checker.sv */
// Scoreboard for the three-digit seven-segment display driver: tracks the
// stored digit patterns and the scan position, and compares every scan word.
// Depends on tdssm_pkg.
`timescale 1ns / 1ps

module tdssm_display_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  tdssm_pkg::item_t   req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  tdssm_pkg::result_t rsp,
    output int                 fail_count,
    output int                 pending
);
    import tdssm_pkg::*;

    localparam int MAX_PRINTS = 40;

    localparam logic [7:0] ASCII_ZERO    = "0";
    localparam logic [7:0] ASCII_NINE    = "9";
    localparam logic [7:0] ASCII_UPPER_A = "A";
    localparam logic [7:0] ASCII_UPPER_Z = "Z";
    localparam logic [7:0] ASCII_LOWER_A = "a";
    localparam logic [7:0] ASCII_LOWER_Z = "z";
    localparam logic [7:0] ASCII_MINUS   = "-";
    localparam logic [7:0] ASCII_SPACE   = " ";

    // Lit segments a..g, active high: digits, letters, minus, blank.
    localparam logic [6:0] LIT_SEGMENTS [0:37] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h74, 7'h04, 7'h1E,
        7'h75, 7'h38, 7'h15, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50, 7'h2D, 7'h78,
        7'h1C, 7'h1C, 7'h3E, 7'h76, 7'h6E, 7'h1B, 7'h40, 7'h00
    };

    logic [7:0] shown [DIGIT_COUNT];
    logic [1:0] scan_pos;
    result_t    scan_words [$];
    result_t    want;

    function automatic logic [7:0] segment_code(input int unsigned g, input logic dot);
        return {~dot, ~LIT_SEGMENTS[g]};
    endfunction

    function automatic bit glyph_of_char(input logic [7:0] code, output int unsigned g);
        g = 0;
        if (code >= ASCII_ZERO && code <= ASCII_NINE)
            g = code - ASCII_ZERO;
        else if (code >= ASCII_UPPER_A && code <= ASCII_UPPER_Z)
            g = code - ASCII_UPPER_A + 10;
        else if (code >= ASCII_LOWER_A && code <= ASCII_LOWER_Z)
            g = code - ASCII_LOWER_A + 10;
        else if (code == ASCII_MINUS)
            g = GLYPH_MINUS;
        else if (code == ASCII_SPACE)
            g = GLYPH_SPACE;
        else
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] exp_val,
                                   input logic [7:0] got_val);
        if (fail_count < MAX_PRINTS)
            $display("ERROR at %0t: %s expected %0h, got %0h",
                     $time, field, exp_val, got_val);
        fail_count++;
    endtask

    task automatic apply_command(input item_t w);
        int          n;
        int unsigned mag;
        int unsigned g;
        logic [1:0]  next_pos;
        result_t     frame;
        case (op_t'(w.operation))
            OP_TICK:
            begin
                // The position moves first; the new position is the one shown.
                next_pos = (int'(scan_pos) + 1 >= DIGIT_COUNT) ? 2'd0 : scan_pos + 2'd1;
                scan_pos = next_pos;
                frame.segment_lines = shown[next_pos];
                frame.digit_enables = ~(3'b001 << next_pos);
                scan_words.push_back(frame);
            end
            OP_WRITE_NUMBER:
            begin
                n = w.number;
                if (n >= NUMBER_MIN && n <= NUMBER_MAX)
                begin
                    if (n < 0)
                    begin
                        shown[2] = segment_code(GLYPH_MINUS, 1'b0);
                        mag = -n;
                    end
                    else
                    begin
                        shown[2] = segment_code(n / 100, 1'b0);
                        mag = n % 100;
                    end
                    shown[1] = segment_code(mag / 10, 1'b0);
                    shown[0] = segment_code(mag % 10, 1'b0);
                end
            end
            OP_WRITE_CHAR:
            begin
                // Unsupported codes leave the digit alone, dot included.
                if (w.digit_index < DIGIT_COUNT && glyph_of_char(w.char_code, g))
                    shown[w.digit_index] = segment_code(g, w.dot_on);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (shown[i])
                shown[i] = RESET_PATTERN;
            scan_pos = 2'd0;
            scan_words.delete();
            fail_count = 0;
        end
        else
        begin
            // A word leaving now belongs to a tick accepted at an earlier edge.
            if (rsp_valid && !rsp_stall)
            begin
                if (scan_words.size() == 0)
                    report_mismatch("unexpected word, segment_lines", 8'h00,
                                    rsp.segment_lines);
                else
                begin
                    want = scan_words.pop_front();
                    if (rsp.segment_lines !== want.segment_lines)
                        report_mismatch("segment_lines", want.segment_lines,
                                        rsp.segment_lines);
                    if (rsp.digit_enables !== want.digit_enables)
                        report_mismatch("digit_enables", 8'(want.digit_enables),
                                        8'(rsp.digit_enables));
                end
            end
            if (req_valid && !req_stall)
                apply_command(req);
        end
        pending <= scan_words.size();
    end

endmodule

/* bench/tb_three_digit_seven_segment_mux_unit.sv */
// Testbench top for the three-digit seven-segment display driver: clock,
// reset, command stimulus, output back-pressure and the verdict.
// Depends on tdssm_pkg, tdssm_display_checker and the block under test.
`timescale 1ns / 1ps

module tb_three_digit_seven_segment_mux_unit;
    import tdssm_pkg::*;

    localparam int LONG_HOLD      = 50;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [7:0] ASCII_ZERO    = "0";
    localparam logic [7:0] ASCII_UPPER_A = "A";
    localparam logic [7:0] ASCII_LOWER_A = "a";
    localparam logic [7:0] ASCII_MINUS   = "-";
    localparam logic [7:0] ASCII_SPACE   = " ";

    logic    clk;
    logic    rst_n;
    logic    req_valid;
    logic    req_stall;
    item_t   req;
    logic    rsp_valid;
    logic    rsp_stall;
    result_t rsp;
    int      fail_count;
    int      pending;
    bit      calm = 1'b0;
    bit      hold_ask = 1'b0;

    three_digit_seven_segment_mux_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    tdssm_display_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic item_t tick_word();
        item_t w;
        w = '0;
        w.operation = OP_TICK;
        return w;
    endfunction

    function automatic item_t number_word(input int value);
        item_t w;
        w = '0;
        w.operation = OP_WRITE_NUMBER;
        w.number = 16'(value);
        return w;
    endfunction

    function automatic item_t char_word(input int idx, input logic [7:0] code, input bit dot);
        item_t w;
        w = '0;
        w.operation = OP_WRITE_CHAR;
        w.digit_index = 2'(idx);
        w.char_code = code;
        w.dot_on = dot;
        return w;
    endfunction

    // Mostly meaningful commands; counted is cleared for words the block may ignore.
    function automatic item_t random_word(output bit counted);
        item_t       w;
        int unsigned roll;
        int unsigned r;
        int          n;
        w.operation = OP_UNUSED;
        w.number = 16'($urandom);
        w.digit_index = 2'($urandom);
        w.char_code = 8'($urandom);
        w.dot_on = 1'($urandom);
        counted = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            w.operation = OP_TICK;
        else if (roll < 65)
        begin
            w.operation = OP_WRITE_NUMBER;
            if (roll < 56)
                w.number = 16'(int'($urandom_range(0, 1098)) - 99);
            else if (roll < 61)
                w.number = 16'(-int'($urandom_range(1, 99)));
            else
            begin
                n = w.number;
                counted = (n >= NUMBER_MIN && n <= NUMBER_MAX);
            end
        end
        else if (roll < 95)
        begin
            w.operation = OP_WRITE_CHAR;
            if (roll < 92)
            begin
                w.digit_index = 2'($urandom_range(0, DIGIT_COUNT - 1));
                r = $urandom_range(0, 63);
                if (r < 10)
                    w.char_code = ASCII_ZERO + 8'(r);
                else if (r < 36)
                    w.char_code = ASCII_UPPER_A + 8'(r - 10);
                else if (r < 62)
                    w.char_code = ASCII_LOWER_A + 8'(r - 36);
                else if (r == 62)
                    w.char_code = ASCII_MINUS;
                else
                    w.char_code = ASCII_SPACE;
            end
            else
                counted = 1'b0;
        end
        else
            counted = 1'b0;
        return w;
    endfunction

    task automatic send_word(input item_t w);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // The pending count is registered and lags behind, so look only from the next edge on.
    task automatic wait_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int words);
        item_t w;
        bit    counted;
        int    done;
        done = 0;
        while (done < words)
        begin
            w = random_word(counted);
            send_word(w);
            if (counted)
                done++;
        end
    endtask

    // Receiver: short random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask)
            begin
                hold_ask = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        item_t odd_word;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset contents, then the number range edges, in and out of range.
        repeat (3) send_word(tick_word());
        send_word(number_word(999));
        send_word(tick_word());
        send_word(number_word(-99));
        send_word(tick_word());
        send_word(number_word(-100));
        send_word(number_word(1000));
        send_word(number_word(-32768));
        send_word(number_word(32767));
        send_word(number_word(0));
        // Characters of every class, dots, unsupported codes, digit index three.
        send_word(char_word(2, "Z", 1'b1));
        send_word(char_word(1, "a", 1'b0));
        send_word(char_word(0, "d", 1'b1));
        send_word(char_word(1, 8'hFF, 1'b0));
        send_word(char_word(1, "@", 1'b1));
        send_word(char_word(3, "9", 1'b1));
        odd_word = '1;
        odd_word.operation = OP_UNUSED;
        send_word(odd_word);
        send_word(char_word(2, "-", 1'b0));
        send_word(char_word(0, " ", 1'b0));
        repeat (3) send_word(tick_word());

        run_random(400);
        // Long output hold-off while ticks keep coming, so the block backs up.
        hold_ask = 1'b1;
        repeat (24) send_word(tick_word());
        run_random(400);
        wait_until_drained();
        run_random(250);
        calm = 1'b1;
        run_random(150);
        wait_until_drained();
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
